[rtl/mtep_pkg.sv]
// Shared types, codes and byte-class functions for the MIDI track event parser.
// No dependencies; imported by every module of the parser.
package mtep_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_ESCAPE   = 8'hF7;
    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
    localparam logic [7:0] ST_UNDEF_F9 = 8'hF9;
    localparam logic [7:0] ST_UNDEF_FD = 8'hFD;
    localparam logic [3:0] HI_PROG     = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [3:0] HI_SYSTEM   = 4'hF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;

    typedef enum logic [2:0] {
        KIND_CHANNEL     = 3'd0,
        KIND_SYSTEM      = 3'd1,
        KIND_SYSEX       = 3'd2,
        KIND_META        = 3'd3,
        KIND_END         = 3'd4,
        KIND_UNSUPPORTED = 3'd5
    } event_kind_t;

    typedef enum logic [3:0] {
        PH_DELTA    = 4'd0,
        PH_STATUS   = 4'd1,
        PH_DATA1    = 4'd2,
        PH_DATA2    = 4'd3,
        PH_SYSLEN   = 4'd4,
        PH_METAKIND = 4'd5,
        PH_METALEN  = 4'd6,
        PH_SKIP     = 4'd7,
        PH_END      = 4'd8
    } phase_t;

    // One classified track byte, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        track_start;
        logic        is_status;
        logic        sets_running;
        logic        is_sysex;
        logic        is_meta;
        logic [1:0]  data_count;
        event_kind_t kind;
    } mtep_item_t;

    function automatic logic [1:0] data_count_of(input logic [7:0] s);
        logic [1:0] cnt;
        begin
            if (s[7:4] == HI_PROG || s[7:4] == HI_PRESSURE)
                cnt = 2'd1;
            else if (s[7:4] != HI_SYSTEM)
                cnt = 2'd2;
            else if (s == ST_MTC || s == ST_SONG_SEL)
                cnt = 2'd1;
            else if (s == ST_SONG_POS)
                cnt = 2'd2;
            else
                cnt = 2'd0;
            return cnt;
        end
    endfunction

    function automatic event_kind_t kind_of(input logic [7:0] s);
        event_kind_t k;
        begin
            if (s[7:4] != HI_SYSTEM)
                k = KIND_CHANNEL;
            else if (s == ST_UNDEF_F4 || s == ST_UNDEF_F5 || s == ST_UNDEF_F9 ||
                     s == ST_UNDEF_FD)
                k = KIND_UNSUPPORTED;
            else
                k = KIND_SYSTEM;
            return k;
        end
    endfunction

endpackage

[rtl/mtep_front.sv]
// Front end: decodes each incoming track byte as a potential status byte.
// Depends on mtep_pkg.
module mtep_front
    import mtep_pkg::*;
(
    input  logic [7:0] stream_byte,
    input  logic       track_start,
    output mtep_item_t item
);

    always_comb
    begin
        item.data_byte    = stream_byte;
        item.track_start  = track_start;
        item.is_status    = stream_byte[7];
        item.sets_running = stream_byte[7] && (stream_byte[7:4] != HI_SYSTEM);
        item.is_sysex     = (stream_byte == ST_SYSEX) || (stream_byte == ST_ESCAPE);
        item.is_meta      = (stream_byte == ST_META);
        item.data_count   = data_count_of(stream_byte);
        item.kind         = kind_of(stream_byte);
    end

endmodule

[rtl/mtep_queue.sv]
// Short FIFO of classified bytes between the front end and the parser core.
// Depends on mtep_pkg.
module mtep_queue
    import mtep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  mtep_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output mtep_item_t pop_item
);

    mtep_item_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/mtep_back.sv]
// Parser core; depends on mtep_pkg. Its event state machine consumes one classified
// byte per cycle unless stalled and loads finished events into the output register.
module mtep_back
    import mtep_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  mtep_item_t    item,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,
    output logic [7:0]    m_tuser
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  status_reg, status_next;
    logic [27:0] delta_reg, delta_next;
    logic [1:0]  vlq_cnt_reg, vlq_cnt_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  meta_reg, meta_next;
    logic [27:0] length_reg, length_next;
    logic [27:0] remain_reg, remain_next;
    logic [1:0]  tempo_idx_reg, tempo_idx_next;
    logic [23:0] tempo_reg, tempo_next;

    logic          out_valid_reg, out_valid_next;
    logic [111:0]  out_data_reg, out_data_next;
    event_kind_t   out_kind_reg, out_kind_next;

    logic          take;
    logic          emit, after_feed, after_end;
    event_kind_t   kind;
    logic [7:0]    d1, d2, b;
    logic [2:0]    vlq_n;
    logic          vlq_done;
    logic          is_meta_kind, has_len;

    assign item_ready = !out_valid_reg || m_tready;
    assign take       = item_valid && item_ready;
    assign b          = item.data_byte;

    // Byte count and end test of the VLQ byte now in hand. A new track restarts
    // the count, since track_start clears all state before the byte is parsed.
    assign vlq_n    = {1'b0, item.track_start ? 2'd0 : vlq_cnt_reg} + 3'd1;
    assign vlq_done = !b[7] || (vlq_n >= 3'(VLQ_MAX_BYTES));

    always_comb
    begin
        phase_next     = phase_reg;
        running_next   = running_reg;
        status_next    = status_reg;
        delta_next     = delta_reg;
        vlq_cnt_next   = vlq_cnt_reg;
        held_next      = held_reg;
        meta_next      = meta_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        tempo_idx_next = tempo_idx_reg;
        tempo_next     = tempo_reg;
        emit           = 1'b0;
        after_feed     = 1'b0;
        after_end      = 1'b0;
        kind           = KIND_CHANNEL;
        d1             = '0;
        d2             = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        is_meta_kind   = 1'b0;
        has_len        = 1'b0;

        if (take)
        begin
            if (item.track_start)
            begin
                phase_next     = PH_DELTA;
                running_next   = '0;
                status_next    = '0;
                delta_next     = '0;
                vlq_cnt_next   = '0;
                held_next      = '0;
                meta_next      = '0;
                length_next    = '0;
                remain_next    = '0;
                tempo_idx_next = '0;
                tempo_next     = '0;
            end

            unique case (phase_next)
                PH_STATUS:
                begin
                    if (item.is_status)
                    begin
                        if (item.sets_running)
                            running_next = b;
                        status_next = b;
                        if (item.is_sysex)
                            phase_next = PH_SYSLEN;
                        else if (item.is_meta)
                            phase_next = PH_METAKIND;
                        else if (item.data_count == 2'd0)
                        begin
                            emit = 1'b1;
                            kind = item.kind;
                        end
                        else
                            phase_next = PH_DATA1;
                    end
                    else if (running_next == '0)
                    begin
                        // Orphan data byte: report it, then reuse it as delta time.
                        emit       = 1'b1;
                        kind       = KIND_UNSUPPORTED;
                        after_feed = 1'b1;
                    end
                    else
                    begin
                        status_next = running_next;
                        if (data_count_of(running_next) == 2'd1)
                        begin
                            emit = 1'b1;
                            kind = kind_of(running_next);
                            d1   = b;
                        end
                        else
                        begin
                            held_next  = b;
                            phase_next = PH_DATA2;
                        end
                    end
                end
                PH_DATA1:
                begin
                    if (data_count_of(status_next) == 2'd1)
                    begin
                        emit = 1'b1;
                        kind = kind_of(status_next);
                        d1   = b;
                    end
                    else
                    begin
                        held_next  = b;
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    emit = 1'b1;
                    kind = kind_of(status_next);
                    d1   = held_next;
                    d2   = b;
                end
                PH_SYSLEN, PH_METALEN:
                begin
                    length_next  = {length_next[20:0], b[6:0]};
                    vlq_cnt_next = vlq_done ? 2'd0 : vlq_n[1:0];
                    if (vlq_done)
                    begin
                        if (phase_next == PH_METALEN && meta_next == META_EOT)
                        begin
                            emit      = 1'b1;
                            kind      = KIND_END;
                            after_end = 1'b1;
                        end
                        else if (length_next == '0)
                        begin
                            emit = 1'b1;
                            kind = (status_next == ST_META) ? KIND_META : KIND_SYSEX;
                        end
                        else
                        begin
                            remain_next = length_next;
                            phase_next  = PH_SKIP;
                        end
                    end
                end
                PH_METAKIND:
                begin
                    meta_next  = b;
                    phase_next = PH_METALEN;
                end
                PH_SKIP:
                begin
                    if (status_next == ST_META && meta_next == META_TEMPO &&
                        tempo_idx_next != 2'd3)
                    begin
                        tempo_next     = {tempo_next[15:0], b};
                        tempo_idx_next = tempo_idx_next + 2'd1;
                    end
                    remain_next = remain_next - 28'd1;
                    if (remain_next == '0)
                    begin
                        emit = 1'b1;
                        kind = (status_next == ST_META) ? KIND_META : KIND_SYSEX;
                    end
                end
                PH_END:
                begin
                end
                default:
                begin
                    delta_next   = {delta_next[20:0], b[6:0]};
                    vlq_cnt_next = vlq_done ? 2'd0 : vlq_n[1:0];
                    phase_next   = vlq_done ? PH_STATUS : PH_DELTA;
                end
            endcase

            if (emit)
            begin
                is_meta_kind   = (kind == KIND_META) || (kind == KIND_END);
                has_len        = is_meta_kind || (kind == KIND_SYSEX);
                out_valid_next = 1'b1;
                out_kind_next  = kind;
                out_data_next  = {
                    (kind == KIND_META && meta_next == META_TEMPO) ? tempo_next : 24'd0,
                    has_len ? length_next : 28'd0,
                    is_meta_kind ? meta_next : 8'd0,
                    delta_next,
                    d2,
                    d1,
                    status_next
                };
                phase_next     = PH_DELTA;
                status_next    = '0;
                delta_next     = '0;
                vlq_cnt_next   = '0;
                held_next      = '0;
                meta_next      = '0;
                length_next    = '0;
                remain_next    = '0;
                tempo_idx_next = '0;
                tempo_next     = '0;
                if (after_feed)
                begin
                    delta_next   = {21'd0, b[6:0]};
                    vlq_cnt_next = vlq_done ? 2'd0 : vlq_n[1:0];
                    phase_next   = vlq_done ? PH_STATUS : PH_DELTA;
                end
                if (after_end)
                    phase_next = PH_END;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DELTA;
            running_reg   <= '0;
            status_reg    <= '0;
            delta_reg     <= '0;
            vlq_cnt_reg   <= '0;
            held_reg      <= '0;
            meta_reg      <= '0;
            length_reg    <= '0;
            remain_reg    <= '0;
            tempo_idx_reg <= '0;
            tempo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            status_reg    <= status_next;
            delta_reg     <= delta_next;
            vlq_cnt_reg   <= vlq_cnt_next;
            held_reg      <= held_next;
            meta_reg      <= meta_next;
            length_reg    <= length_next;
            remain_reg    <= remain_next;
            tempo_idx_reg <= tempo_idx_next;
            tempo_reg     <= tempo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {5'd0, out_kind_reg};

endmodule

[rtl/midi_track_event_parser.sv]
// Top level of the MIDI track event parser: front end, byte queue and parser core.
// Depends on mtep_pkg, mtep_front, mtep_queue and mtep_back.
//
// The parser takes one track byte per clock and gives at most one event per byte.
// A byte goes through a four-entry queue into the parser core, which decodes it
// combinationally and loads the event that the byte completes into its output
// register. The rate is one byte per cycle for as long as the output side takes
// events, and the queue absorbs short output stalls. A byte with track_start set
// clears all state, including running status, before it is parsed. Delta-time and
// length quantities end after VLQ_MAX_BYTES bytes and are kept to 28 bits.
module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] stream_byte
    input  logic [7:0]    s_tuser,   // [0] track_start
    output logic          m_tvalid,
    input  logic          m_tready,
    // [7:0] status_byte, [15:8] first_data, [23:16] second_data,
    // [51:24] delta_ticks, [59:52] meta_kind, [87:60] payload_length,
    // [111:88] tempo_value
    output logic [111:0]  m_tdata,
    output logic [7:0]    m_tuser    // [2:0] event_kind
);

    mtep_item_t front_item;
    mtep_item_t core_item;
    logic       core_valid;
    logic       core_ready;

    mtep_front u_front (
        .stream_byte (s_tdata),
        .track_start (s_tuser[0]),
        .item        (front_item)
    );

    mtep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (core_valid),
        .pop_ready  (core_ready),
        .pop_item   (core_item)
    );

    mtep_back #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (core_valid),
        .item_ready (core_ready),
        .item       (core_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
